@@ design/vmp_pkg.sv @@
// ----------------------------------------------------------------------------
// vmp_pkg
// Shared types and constants of the vector-matrix product block.
// ----------------------------------------------------------------------------
`default_nettype none

package vmp_pkg;

  // operand and result widths
  localparam int unsigned VAL_W      = 16;  // signed Q1.15 operands
  localparam int unsigned PROD_W     = 32;  // exact Q2.30 product
  localparam int unsigned ACC_W      = 48;  // Q18.30 accumulator
  localparam int unsigned COL_IDX_W  = 10;  // column index on the result word

  // stream word widths
  localparam int unsigned IN_DATA_W  = 2 * VAL_W;
  localparam int unsigned OUT_USED_W = COL_IDX_W + ACC_W;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned ROWS_REG_W = 13;
  localparam int unsigned COLS_REG_W = 11;
  localparam int unsigned CFG_DATA_W = ROWS_REG_W;

  localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS = 1'b1;

  // position flags worked out by the front end for each word
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic last_col;
  } vmp_flags_t;

endpackage

`default_nettype wire

@@ design/vmp_front.sv @@
// ----------------------------------------------------------------------------
// vmp_front
// Holds the size registers, tracks row and column of the incoming stream and
// tags each word with its position before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vmp_front #(
  parameter int unsigned MAX_ROWS = 4096,
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned RW       = 12,
  parameter int unsigned CW       = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [vmp_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [vmp_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [vmp_pkg::IN_DATA_W-1:0]   in_data_i,
  output logic                                 push_o,
  input  wire logic                            push_ready_i,
  output logic [CW-1:0]                        col_o,
  output vmp_pkg::vmp_flags_t                  flags_o,
  output logic [vmp_pkg::VAL_W-1:0]            vec_o,
  output logic [vmp_pkg::VAL_W-1:0]            mat_o
);

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] last_row_idx_q;
  logic [CW-1:0] last_col_idx_q;
  logic          is_last_row;
  logic          is_last_col;
  logic          accept;
  logic [31:0]   rows_wide;
  logic [31:0]   cols_wide;
  logic [31:0]   rows_last;
  logic [31:0]   cols_last;

  // clamp written sizes to 1..max and keep the index of the last row/column
  always_comb begin
    rows_wide = 32'(cfg_wdata_i[vmp_pkg::ROWS_REG_W-1:0]);
    cols_wide = 32'(cfg_wdata_i[vmp_pkg::COLS_REG_W-1:0]);
    if (rows_wide == 32'd0) begin
      rows_last = 32'd0;
    end else if (rows_wide > MAX_ROWS) begin
      rows_last = MAX_ROWS - 1;
    end else begin
      rows_last = rows_wide - 32'd1;
    end
    if (cols_wide == 32'd0) begin
      cols_last = 32'd0;
    end else if (cols_wide > MAX_COLS) begin
      cols_last = MAX_COLS - 1;
    end else begin
      cols_last = cols_wide - 32'd1;
    end
  end

  // position of the current word
  assign accept      = in_valid_i && push_ready_i;
  assign is_last_row = (row_q >= last_row_idx_q);
  assign is_last_col = (col_q >= last_col_idx_q);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (is_last_col) begin
        col_d = '0;
        row_d = is_last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // counters and size registers; a size write restarts the stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q          <= '0;
      col_q          <= '0;
      last_row_idx_q <= '0;
      last_col_idx_q <= '0;
    end else if (cfg_we_i) begin
      row_q <= '0;
      col_q <= '0;
      unique case (cfg_addr_i)
        vmp_pkg::REG_NUM_ROWS: last_row_idx_q <= rows_last[RW-1:0];
        vmp_pkg::REG_NUM_COLS: last_col_idx_q <= cols_last[CW-1:0];
        default: ;
      endcase
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // tagged word towards the queue
  assign in_ready_o          = push_ready_i;
  assign push_o              = accept;
  assign col_o               = col_q;
  assign flags_o.first_row   = (row_q == '0);
  assign flags_o.last_row    = is_last_row;
  assign flags_o.last_col    = is_last_col;
  assign vec_o               = in_data_i[vmp_pkg::VAL_W-1:0];
  assign mat_o               = in_data_i[vmp_pkg::IN_DATA_W-1:vmp_pkg::VAL_W];

endmodule

`default_nettype wire

@@ design/vmp_queue.sv @@
// ----------------------------------------------------------------------------
// vmp_queue
// Small register FIFO between the front end and the accumulate engine.
// ----------------------------------------------------------------------------
`default_nettype none

module vmp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q;
  logic [AW-1:0]    rd_ptr_q;
  logic [AW:0]      count_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (count_q != (AW+1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ design/vmp_back.sv @@
// ----------------------------------------------------------------------------
// vmp_back
// Multiply-accumulate engine: multiplies each word, adds it into the column
// accumulator store and hands finished column sums to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vmp_back #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned CW       = 10
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              q_valid_i,
  output logic                                   q_pop_o,
  input  wire logic [CW-1:0]                     q_col_i,
  input  wire vmp_pkg::vmp_flags_t               q_flags_i,
  input  wire logic [vmp_pkg::VAL_W-1:0]         q_vec_i,
  input  wire logic [vmp_pkg::VAL_W-1:0]         q_mat_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [vmp_pkg::COL_IDX_W-1:0]          out_col_o,
  output logic [vmp_pkg::ACC_W-1:0]              out_sum_o,
  output logic                                   out_last_o
);

  // column accumulator store
  logic [vmp_pkg::ACC_W-1:0] acc_mem [MAX_COLS];

  // multiply stage
  logic                         a_valid_q;
  logic [CW-1:0]                a_col_q;
  vmp_pkg::vmp_flags_t          a_flags_q;
  logic signed [vmp_pkg::PROD_W-1:0] a_prod_q;
  logic [vmp_pkg::ACC_W-1:0]    a_rd_q;
  logic                         a_fwd_q;
  logic [vmp_pkg::ACC_W-1:0]    a_fwd_val_q;

  logic signed [vmp_pkg::PROD_W-1:0] prod_d;
  logic [vmp_pkg::ACC_W-1:0]    prod_ext;
  logic [vmp_pkg::ACC_W-1:0]    base;
  logic [vmp_pkg::ACC_W-1:0]    acc_sum;
  logic                         out_free;
  logic                         a_adv;
  logic                         a_ready;
  logic                         pop;
  logic                         emit;
  logic [31:0]                  col_wide;

  // handshake between stages
  assign out_free = !out_valid_o || out_ready_i;
  assign a_adv    = a_valid_q && (!a_flags_q.last_row || out_free);
  assign a_ready  = !a_valid_q || a_adv;
  assign pop      = q_valid_i && a_ready;
  assign q_pop_o  = pop;
  assign emit     = a_adv && a_flags_q.last_row;

  // product of the word leaving the queue
  assign prod_d = $signed(q_vec_i) * $signed(q_mat_i);

  // accumulate, with the value written this edge forwarded to the next word
  assign prod_ext = {{(vmp_pkg::ACC_W - vmp_pkg::PROD_W){a_prod_q[vmp_pkg::PROD_W-1]}},
                     a_prod_q};
  assign base     = a_fwd_q ? a_fwd_val_q : a_rd_q;
  assign acc_sum  = a_flags_q.first_row ? prod_ext : base + prod_ext;
  assign col_wide = 32'(a_col_q);

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (pop) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_col_q     <= q_col_i;
      a_flags_q   <= q_flags_i;
      a_prod_q    <= prod_d;
      a_fwd_q     <= a_adv && (a_col_q == q_col_i);
      a_fwd_val_q <= acc_sum;
    end
    if (emit) begin
      out_col_o  <= col_wide[vmp_pkg::COL_IDX_W-1:0];
      out_sum_o  <= acc_sum;
      out_last_o <= a_flags_q.last_col;
    end
  end

  // store read and write ports
  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_rd_q <= acc_mem[q_col_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      acc_mem[a_col_q] <= acc_sum;
    end
  end

endmodule

`default_nettype wire

@@ design/vector_matrix_product.sv @@
// A word that is taken passes the queue, the multiply stage and the output
// register before its column sum shows.
// Throughput: one matrix word per cycle unless the output holds off, bounded by
// the read and write ports of the column accumulator store and the one multiplier.
// Reset: counters, queue and valid flags clear; sizes return to one row and one
// column. The accumulator store is not cleared, row 0 overwrites each entry.
// ----------------------------------------------------------------------------
// vector_matrix_product
// Streams a row-major matrix with its vector elements and returns each
// column's Q18.30 dot product on the last row.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_matrix_product #(
  parameter int unsigned MAX_ROWS = 4096,
  parameter int unsigned MAX_COLS = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [vmp_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [vmp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // vec_value [15:0], mat_value [31:16]
  input  wire logic [vmp_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // col_index [9:0], sum_value [57:10], zero pad [63:58]
  output logic [vmp_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o,
  output logic                                   m_axis_tlast_o
);

  localparam int unsigned RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned FLAGS_W = $bits(vmp_pkg::vmp_flags_t);
  localparam int unsigned Q_W     = CW + FLAGS_W + 2 * vmp_pkg::VAL_W;
  localparam int unsigned Q_DEPTH = 4;

  logic                          push;
  logic                          push_ready;
  logic [CW-1:0]                 f_col;
  vmp_pkg::vmp_flags_t           f_flags;
  logic [vmp_pkg::VAL_W-1:0]     f_vec;
  logic [vmp_pkg::VAL_W-1:0]     f_mat;
  logic                          q_valid;
  logic                          q_pop;
  logic [Q_W-1:0]                q_data;
  logic [CW-1:0]                 b_col;
  vmp_pkg::vmp_flags_t           b_flags;
  logic [vmp_pkg::VAL_W-1:0]     b_vec;
  logic [vmp_pkg::VAL_W-1:0]     b_mat;
  logic [vmp_pkg::COL_IDX_W-1:0] out_col;
  logic [vmp_pkg::ACC_W-1:0]     out_sum;

  // position tracking and size registers
  vmp_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .CW       (CW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .col_o        (f_col),
    .flags_o      (f_flags),
    .vec_o        (f_vec),
    .mat_o        (f_mat)
  );

  // decoupling queue
  vmp_queue #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  ({f_col, f_flags, f_mat, f_vec}),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_data)
  );

  assign {b_col, b_flags, b_mat, b_vec} = q_data;

  // multiply-accumulate engine
  vmp_back #(
    .MAX_COLS (MAX_COLS),
    .CW       (CW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_col_i     (b_col),
    .q_flags_i   (b_flags),
    .q_vec_i     (b_vec),
    .q_mat_i     (b_mat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_col_o   (out_col),
    .out_sum_o   (out_sum),
    .out_last_o  (m_axis_tlast_o)
  );

  // result word
  assign m_axis_tdata_o = {{vmp_pkg::OUT_PAD_W{1'b0}}, out_sum, out_col};

endmodule

`default_nettype wire

@@ test/tb_vector_matrix_product.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector_matrix_product
// Self-checking bench for the vector-matrix product block. A short table of
// directed words and register writes opens the run. Matrices with random
// sizes and contents follow, under changing idle patterns on both streams
// and one long hold-off at the output. Every column sum is checked against
// a hand-given sum in the directed table, else a predictor kept in the bench.
// ----------------------------------------------------------------------------

module tb_vector_matrix_product;

  import vmp_pkg::*;

  localparam int unsigned MAX_ROWS_P     = 4096;
  localparam int unsigned MAX_COLS_P     = 1024;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RAND_WORDS     = 220;
  localparam int unsigned HOLD_AT_RESULT = 200;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned DIR_LEN        = 25;

  typedef enum logic {STEP_WORD, STEP_CFG} step_e;
  typedef enum logic {FILL_RANDOM, FILL_MIN} fill_e;

  // one finished column sum as it leaves the block
  typedef struct packed {
    logic [COL_IDX_W-1:0]    col;
    logic signed [ACC_W-1:0] sum;
    logic                    last;
  } col_sum_t;

  // one row of the directed table
  typedef struct packed {
    step_e                 kind;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [VAL_W-1:0]      vec;
    logic [VAL_W-1:0]      mat;
    logic                  typed;
    col_sum_t              want;
  } dir_row_t;

  localparam logic [VAL_W-1:0] V_MIN = 16'h8000;
  localparam logic [VAL_W-1:0] V_MAX = 16'h7FFF;

  // expected sums are given only where they are obvious by hand
  localparam dir_row_t DIR_TAB [DIR_LEN] = '{
    // after reset: one row, one column, every word is its own product
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, V_MAX, V_MAX, 1'b1, '{10'd0, 48'sd1073676289, 1'b1}},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, V_MIN, V_MIN, 1'b1, '{10'd0, 48'sd1073741824, 1'b1}},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, V_MIN, V_MAX, 1'b1, '{10'd0, -48'sd1073709056, 1'b1}},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, 16'h0000, 16'hFFFF, 1'b1, '{10'd0, 48'sd0, 1'b1}},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, 16'hFFFF, 16'hFFFF, 1'b1, '{10'd0, 48'sd1, 1'b1}},
    // zero rows acts as one row, three columns
    '{STEP_CFG, REG_NUM_ROWS, 13'd0, 16'h0, 16'h0, 1'b0, '0},
    '{STEP_CFG, REG_NUM_COLS, 13'd3, 16'h0, 16'h0, 1'b0, '0},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, 16'sd2, 16'sd3, 1'b1, '{10'd0, 48'sd6, 1'b0}},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, -16'sd2, 16'sd5, 1'b1, '{10'd1, -48'sd10, 1'b0}},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, 16'sd100, -16'sd100, 1'b1,
      '{10'd2, -48'sd10000, 1'b1}},
    // two by two: sums appear only on the second row
    '{STEP_CFG, REG_NUM_ROWS, 13'd2, 16'h0, 16'h0, 1'b0, '0},
    '{STEP_CFG, REG_NUM_COLS, 13'd2, 16'h0, 16'h0, 1'b0, '0},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, 16'sd3, 16'sd4, 1'b0, '0},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, 16'sd3, -16'sd5, 1'b0, '0},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, -16'sd2, 16'sd7, 1'b1, '{10'd0, -48'sd2, 1'b0}},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, -16'sd2, -16'sd8, 1'b1, '{10'd1, 48'sd1, 1'b1}},
    // three rows of the largest product pile up past 32 bits
    '{STEP_CFG, REG_NUM_COLS, 13'd1, 16'h0, 16'h0, 1'b0, '0},
    '{STEP_CFG, REG_NUM_ROWS, 13'd3, 16'h0, 16'h0, 1'b0, '0},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, V_MIN, V_MIN, 1'b0, '0},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, V_MIN, V_MIN, 1'b0, '0},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, V_MIN, V_MIN, 1'b1,
      '{10'd0, 48'sd3221225472, 1'b1}},
    // zero columns acts as one column
    '{STEP_CFG, REG_NUM_ROWS, 13'd1, 16'h0, 16'h0, 1'b0, '0},
    '{STEP_CFG, REG_NUM_COLS, 13'd0, 16'h0, 16'h0, 1'b0, '0},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, 16'sd5, -16'sd7, 1'b1, '{10'd0, -48'sd35, 1'b1}},
    '{STEP_WORD, REG_NUM_ROWS, 13'd0, V_MAX, V_MIN, 1'b1,
      '{10'd0, -48'sd1073709056, 1'b1}}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;   // vec_value [15:0], mat_value [31:16]
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;   // col_index [9:0], sum_value [57:10], pad
  logic                  m_axis_tlast_o;

  vector_matrix_product #(
    .MAX_ROWS (MAX_ROWS_P),
    .MAX_COLS (MAX_COLS_P)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // predictor state: its own copy of sizes, position and column sums
  logic signed [ACC_W-1:0] acc_model [MAX_COLS_P];
  logic [CFG_DATA_W-1:0]   rows_reg;
  logic [CFG_DATA_W-1:0]   cols_reg;
  int unsigned             row_at;
  int unsigned             col_at;

  col_sum_t    col_sum_q [$];
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned sums_checked;
  int unsigned reg_writes;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // size register as the block uses it: zero means one, large values clamp
  function automatic int unsigned eff_count(input int unsigned v, input int unsigned max);
    if (v == 0) return 1;
    if (v > max) return max;
    return v;
  endfunction

  function automatic void model_reg_write(input logic [CFG_ADDR_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_NUM_ROWS) begin
      rows_reg = val;
    end else begin
      cols_reg = {2'b00, val[COLS_REG_W-1:0]};
    end
    row_at = 0;
    col_at = 0;
  endfunction

  // accumulate one matrix word; returns 1 when it finishes a column
  function automatic bit predict_sum(input logic signed [VAL_W-1:0] v,
                                     input logic signed [VAL_W-1:0] m,
                                     output col_sum_t res);
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    int unsigned              rows;
    int unsigned              cols;
    bit                       last_row;
    bit                       last_c;
    rows     = eff_count(rows_reg, MAX_ROWS_P);
    cols     = eff_count(cols_reg, MAX_COLS_P);
    prod     = v * m;
    last_row = (row_at >= rows - 1);
    last_c   = (col_at >= cols - 1);
    if (row_at == 0) begin
      acc = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end else begin
      acc = acc_model[col_at] + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    acc_model[col_at] = acc;
    res.col  = col_at[COL_IDX_W-1:0];
    res.sum  = acc;
    res.last = last_c;
    if (last_c) begin
      col_at = 0;
      row_at = last_row ? 0 : row_at + 1;
    end else begin
      col_at = col_at + 1;
    end
    return last_row;
  endfunction

  // offer one word, with random gaps before it, until taken
  task automatic send_word(input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] m);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {m, v};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    words_sent++;
  endtask

  // stop offering and let every outstanding word work its way through
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (col_sum_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    model_reg_write(idx, val);
    reg_writes++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value(input fill_e fill);
    if (fill == FILL_MIN) return V_MIN;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       return V_MIN;
        1:       return V_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return VAL_W'($urandom());
  endfunction

  // set the sizes, then stream whole matrices and maybe a cut-off tail
  task automatic run_phase(input logic [CFG_DATA_W-1:0] rows_val,
                           input logic [CFG_DATA_W-1:0] cols_val,
                           input int unsigned mats, input bit cut_short,
                           input fill_e fill);
    int unsigned per_mat;
    int unsigned total;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] m;
    col_sum_t res;
    settle_block();
    if ($urandom_range(1) == 0) begin
      write_reg(REG_NUM_ROWS, rows_val);
      write_reg(REG_NUM_COLS, cols_val);
    end else begin
      write_reg(REG_NUM_COLS, cols_val);
      write_reg(REG_NUM_ROWS, rows_val);
    end
    per_mat = eff_count(rows_reg, MAX_ROWS_P) * eff_count(cols_reg, MAX_COLS_P);
    total   = mats * per_mat;
    if (cut_short && per_mat > 1) total += $urandom_range(per_mat - 1, 1);
    repeat (total) begin
      v = pick_value(fill);
      m = pick_value(fill);
      send_word(v, m);
      if (predict_sum(v, m, res)) col_sum_q.push_back(res);
    end
  endtask

  // result side: random stalls plus one long hold-off that backs the block up
  initial begin
    bit hold_done;
    hold_done       = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && sums_checked >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each column sum with the oldest expectation
  always @(posedge clk_i) begin
    col_sum_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (col_sum_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word col %0d sum %0d",
                                  m_axis_tdata_o[9:0], $signed(m_axis_tdata_o[57:10])));
      end else begin
        want = col_sum_q.pop_front();
        if (m_axis_tdata_o[9:0] !== want.col)
          report_mismatch($sformatf("col_index %0d, want %0d",
                                    m_axis_tdata_o[9:0], want.col));
        if (m_axis_tdata_o[57:10] !== want.sum)
          report_mismatch($sformatf("col %0d sum_value %0d, want %0d", want.col,
                                    $signed(m_axis_tdata_o[57:10]), want.sum));
        if (m_axis_tlast_o !== want.last)
          report_mismatch($sformatf("col %0d tlast %0b, want %0b", want.col,
                                    m_axis_tlast_o, want.last));
      end
      sums_checked++;
    end
  end

  // stimulus
  initial begin
    col_sum_t    res;
    bit          got;
    int unsigned base;
    int unsigned stage;
    logic [CFG_DATA_W-1:0] rows_val;
    logic [CFG_DATA_W-1:0] cols_val;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = '0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    mismatches      = 0;
    words_sent      = 0;
    sums_checked    = 0;
    reg_writes      = 0;
    cycle_count     = 0;
    send_idle_pct   = 8;
    recv_idle_pct   = 49;
    rows_reg        = 1;
    cols_reg        = 1;
    row_at          = 0;
    col_at          = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_LEN; i++) begin
      if (DIR_TAB[i].kind == STEP_CFG) begin
        settle_block();
        write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].reg_val);
      end else begin
        send_word(DIR_TAB[i].vec, DIR_TAB[i].mat);
        got = predict_sum(DIR_TAB[i].vec, DIR_TAB[i].mat, res);
        if (got) col_sum_q.push_back(DIR_TAB[i].typed ? DIR_TAB[i].want : res);
      end
    end

    // oversized column write clamps to the largest column count
    run_phase(13'd1, 13'd2047, 1, 1'b0, FILL_RANDOM);

    // random sizes, mostly small, under three idle patterns in turn
    base = words_sent;
    while (words_sent - base < RAND_WORDS) begin
      stage = (words_sent - base) * 3 / RAND_WORDS;
      case (stage)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case ($urandom_range(19))
        0:       rows_val = '0;
        1:       rows_val = CFG_DATA_W'($urandom_range(10, 7));
        default: rows_val = CFG_DATA_W'($urandom_range(6, 1));
      endcase
      case ($urandom_range(19))
        0:       cols_val = '0;
        1:       cols_val = CFG_DATA_W'($urandom_range(16, 13));
        default: cols_val = CFG_DATA_W'($urandom_range(12, 1));
      endcase
      run_phase(rows_val, cols_val, $urandom_range(2, 1), $urandom_range(4) == 0,
                FILL_RANDOM);
    end

    settle_block();
    $display("summary: %0d matrix words, %0d column sums, %0d register writes",
             words_sent, sums_checked, reg_writes);
    $display("summary: zero and oversized sizes, idle mixes and a long stall, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
